>>> src/ofb_pkg.sv
package ofb_pkg;

	localparam int MAX_FRAME_LEN = 16;
	localparam int MAX_CHANNELS  = 4;
	localparam int SAMPLE_BITS   = 16;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;
	localparam int WIDTH_W    = 5;
	localparam int NCH_W      = 3;
	localparam int CHAN_W     = 2;
	localparam int POS_W      = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INPUT_WIDTH  = 2'd0,
		REG_OUTPUT_WIDTH = 2'd1,
		REG_NUM_CHANNELS = 2'd2,
		REG_COL_MAJOR    = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_COLLECT,
		S_EMIT_RD,
		S_EMIT_LD,
		S_KEEP_RD,
		S_KEEP_WR,
		S_HS_UPD
	} state_t;

	typedef struct packed {
		logic frame_we;
		logic hist_we;
		logic hist_clear;
		logic sel_hist;
	} mem_ctl_t;

	typedef struct packed {
		logic              load;
		logic [CHAN_W-1:0] channel;
		logic [POS_W-1:0]  position;
		logic              last;
	} oreg_ctl_t;

endpackage

>>> src/ofb_if.sv
interface ofb_in_if #(
	parameter int SAMPLE_BITS = ofb_pkg::SAMPLE_BITS
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface ofb_out_if #(
	parameter int SAMPLE_BITS = ofb_pkg::SAMPLE_BITS
);
	import ofb_pkg::*;

	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] out_sample;
	logic [CHAN_W-1:0]             out_channel;
	logic [POS_W-1:0]              out_position;
	logic                          frame_last;

	modport source (
		output valid, output out_sample, output out_channel,
		output out_position, output frame_last, input ready
	);
	modport sink (
		input valid, input out_sample, input out_channel,
		input out_position, input frame_last, output ready
	);
endinterface

>>> src/ofb_mem.sv
module ofb_mem #(
	parameter int MAX_FRAME_LEN = ofb_pkg::MAX_FRAME_LEN,
	parameter int MAX_CHANNELS  = ofb_pkg::MAX_CHANNELS,
	parameter int SAMPLE_BITS   = ofb_pkg::SAMPLE_BITS,
	localparam int DEPTH        = MAX_FRAME_LEN * MAX_CHANNELS,
	localparam int AW           = $clog2(DEPTH)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ofb_pkg::mem_ctl_t             ctl,
	input  logic [AW-1:0]                 frame_waddr,
	input  logic [AW-1:0]                 frame_raddr,
	input  logic [AW-1:0]                 hist_addr,
	input  logic signed [SAMPLE_BITS-1:0] wdata,
	output logic signed [SAMPLE_BITS-1:0] rdata
);
	import ofb_pkg::*;

	logic signed [SAMPLE_BITS-1:0] frame_mem_q [DEPTH];
	logic signed [SAMPLE_BITS-1:0] hist_mem_q [DEPTH];
	logic [DEPTH-1:0]              hist_valid_q;
	logic signed [SAMPLE_BITS-1:0] frame_rd_q;
	logic signed [SAMPLE_BITS-1:0] hist_rd_q;
	logic                          hist_rd_valid_q;
	logic                          sel_hist_q;

	always_ff @(posedge clk) begin
		if (ctl.frame_we) begin
			frame_mem_q[frame_waddr] <= wdata;
		end
		frame_rd_q <= frame_mem_q[frame_raddr];
	end

	always_ff @(posedge clk) begin
		if (ctl.hist_we) begin
			hist_mem_q[hist_addr] <= frame_rd_q;
		end
		hist_rd_q <= hist_mem_q[hist_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_valid_q    <= '0;
			hist_rd_valid_q <= 1'b0;
			sel_hist_q      <= 1'b0;
		end else begin
			if (ctl.hist_clear) begin
				hist_valid_q <= '0;
			end else if (ctl.hist_we) begin
				hist_valid_q[hist_addr] <= 1'b1;
			end
			hist_rd_valid_q <= hist_valid_q[hist_addr];
			sel_hist_q      <= ctl.sel_hist;
		end
	end

	always_comb begin
		if (sel_hist_q) begin
			rdata = hist_rd_valid_q ? hist_rd_q : '0;
		end else begin
			rdata = frame_rd_q;
		end
	end

endmodule

>>> src/ofb_oreg.sv
module ofb_oreg #(
	parameter int SAMPLE_BITS = ofb_pkg::SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ofb_pkg::oreg_ctl_t            ctl,
	input  logic signed [SAMPLE_BITS-1:0] data,
	output logic                          room,
	ofb_out_if.source                     dout
);
	import ofb_pkg::*;

	logic                          valid_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic [CHAN_W-1:0]             channel_q;
	logic [POS_W-1:0]              position_q;
	logic                          last_q;

	assign room = !valid_q || dout.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.load) begin
			valid_q <= 1'b1;
		end else if (dout.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			sample_q   <= data;
			channel_q  <= ctl.channel;
			position_q <= ctl.position;
			last_q     <= ctl.last;
		end
	end

	assign dout.valid        = valid_q;
	assign dout.out_sample   = sample_q;
	assign dout.out_channel  = channel_q;
	assign dout.out_position = position_q;
	assign dout.frame_last   = last_q;

endmodule

>>> src/ofb_ctrl.sv
module ofb_ctrl #(
	parameter int MAX_FRAME_LEN = ofb_pkg::MAX_FRAME_LEN,
	parameter int MAX_CHANNELS  = ofb_pkg::MAX_CHANNELS,
	localparam int DEPTH        = MAX_FRAME_LEN * MAX_CHANNELS,
	localparam int AW           = $clog2(DEPTH)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ofb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ofb_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             room,
	output ofb_pkg::mem_ctl_t                mem_ctl,
	output logic [AW-1:0]                    frame_waddr,
	output logic [AW-1:0]                    frame_raddr,
	output logic [AW-1:0]                    hist_addr,
	output ofb_pkg::oreg_ctl_t               oreg_ctl
);
	import ofb_pkg::*;

	localparam int PW = $clog2(MAX_FRAME_LEN);
	localparam int LW = $clog2(MAX_FRAME_LEN + 1);
	localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int NW = $clog2(MAX_CHANNELS + 1);
	localparam int TW = $clog2(DEPTH + 1);
	localparam int XW = AW + 1;

	logic [WIDTH_W-1:0] in_w_q;
	logic [WIDTH_W-1:0] out_w_q;
	logic [NCH_W-1:0]   nch_q;
	logic               col_q;

	state_t         state_q, state_d;
	logic [TW-1:0]  fill_q;
	logic [CW-1:0]  ch_q;
	logic [PW-1:0]  pos_q;
	logic [PW-1:0]  hs_q;

	logic [LW-1:0]  iw, ow, ov, nkeep, wop, ip;
	logic [NW-1:0]  nch;
	logic [TW-1:0]  total;
	logic [LW:0]    wsum, wrapped;
	logic [PW-1:0]  hp, hoff;
	logic           accept, frame_done, last_pos, last_ch, last_item, last_k, sel_hist;
	logic           keep_tail;

	// effective register values
	always_comb begin
		if (in_w_q == '0) begin
			iw = LW'(1);
		end else if (int'(in_w_q) > MAX_FRAME_LEN) begin
			iw = LW'(MAX_FRAME_LEN);
		end else begin
			iw = LW'(in_w_q);
		end
		if (int'(out_w_q) > MAX_FRAME_LEN) begin
			ow = LW'(MAX_FRAME_LEN);
		end else begin
			ow = LW'(out_w_q);
		end
		if (ow < iw) begin
			ow = iw;
		end
		if (nch_q == '0) begin
			nch = NW'(1);
		end else if (int'(nch_q) > MAX_CHANNELS) begin
			nch = NW'(MAX_CHANNELS);
		end else begin
			nch = NW'(nch_q);
		end
	end

	assign ov        = ow - iw;
	assign keep_tail = (ov <= iw);
	assign nkeep     = keep_tail ? ov : iw;
	assign total     = TW'(iw) * TW'(nch);

	assign accept     = in_valid && in_ready;
	assign frame_done = (fill_q + TW'(1)) == total;
	assign last_pos   = LW'(pos_q) == (ow - LW'(1));
	assign last_ch    = NW'(ch_q) == (nch - NW'(1));
	assign last_item  = last_pos && last_ch;
	assign last_k     = LW'(pos_q) == (nkeep - LW'(1));
	assign sel_hist   = LW'(pos_q) < ov;

	// shared ring add and wrap
	assign wop     = (state_q == S_HS_UPD) ? iw : LW'(pos_q);
	assign wsum    = (LW + 1)'(hs_q) + (LW + 1)'(wop);
	assign wrapped = (wsum >= (LW + 1)'(ov)) ? wsum - (LW + 1)'(ov) : wsum;
	assign hp      = PW'(wrapped);

	// shared input frame index unit
	always_comb begin
		if (state_q == S_KEEP_RD || state_q == S_KEEP_WR) begin
			ip = keep_tail ? (iw - ov + LW'(pos_q)) : LW'(pos_q);
		end else begin
			ip = LW'(pos_q) - ov;
		end
		if (col_q) begin
			frame_raddr = AW'(XW'(ip) + XW'(iw) * XW'(ch_q));
		end else begin
			frame_raddr = AW'(XW'(nch) * XW'(ip) + XW'(ch_q));
		end
	end

	assign hoff        = ((state_q == S_KEEP_WR) && keep_tail) ? pos_q : hp;
	assign hist_addr   = AW'(XW'(ch_q) * XW'(MAX_FRAME_LEN) + XW'(hoff));
	assign frame_waddr = AW'(fill_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_COLLECT: begin
				if (accept && frame_done) begin
					state_d = S_EMIT_RD;
				end
			end
			S_EMIT_RD: begin
				state_d = S_EMIT_LD;
			end
			S_EMIT_LD: begin
				if (room) begin
					if (!last_item) begin
						state_d = S_EMIT_RD;
					end else if (nkeep == '0) begin
						state_d = S_HS_UPD;
					end else begin
						state_d = S_KEEP_RD;
					end
				end
			end
			S_KEEP_RD: begin
				state_d = S_KEEP_WR;
			end
			S_KEEP_WR: begin
				if (last_k && last_ch) begin
					state_d = S_HS_UPD;
				end else begin
					state_d = S_KEEP_RD;
				end
			end
			S_HS_UPD: begin
				state_d = S_COLLECT;
			end
			default: begin
				state_d = S_COLLECT;
			end
		endcase
	end

	// outputs
	always_comb begin
		in_ready            = (state_q == S_COLLECT);
		mem_ctl.frame_we    = accept;
		mem_ctl.hist_we     = (state_q == S_KEEP_WR);
		mem_ctl.hist_clear  = cfg_we;
		mem_ctl.sel_hist    = sel_hist;
		oreg_ctl.load       = (state_q == S_EMIT_LD) && room;
		oreg_ctl.channel    = CHAN_W'(ch_q);
		oreg_ctl.position   = POS_W'(pos_q);
		oreg_ctl.last       = last_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_w_q  <= WIDTH_W'(1);
			out_w_q <= WIDTH_W'(2);
			nch_q   <= NCH_W'(1);
			col_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_INPUT_WIDTH:  in_w_q  <= cfg_data[WIDTH_W-1:0];
				REG_OUTPUT_WIDTH: out_w_q <= cfg_data[WIDTH_W-1:0];
				REG_NUM_CHANNELS: nch_q   <= cfg_data[NCH_W-1:0];
				REG_COL_MAJOR:    col_q   <= cfg_data[0];
				default:          col_q   <= col_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_COLLECT;
			fill_q  <= '0;
			ch_q    <= '0;
			pos_q   <= '0;
			hs_q    <= '0;
		end else if (cfg_we) begin
			state_q <= S_COLLECT;
			fill_q  <= '0;
			ch_q    <= '0;
			pos_q   <= '0;
			hs_q    <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_COLLECT: begin
					if (accept) begin
						fill_q <= frame_done ? '0 : fill_q + TW'(1);
						ch_q   <= '0;
						pos_q  <= '0;
					end
				end
				S_EMIT_LD: begin
					if (room) begin
						if (last_item) begin
							ch_q  <= '0;
							pos_q <= '0;
						end else if (col_q) begin
							if (last_pos) begin
								pos_q <= '0;
								ch_q  <= ch_q + CW'(1);
							end else begin
								pos_q <= pos_q + PW'(1);
							end
						end else begin
							if (last_ch) begin
								ch_q  <= '0;
								pos_q <= pos_q + PW'(1);
							end else begin
								ch_q <= ch_q + CW'(1);
							end
						end
					end
				end
				S_KEEP_WR: begin
					if (last_k) begin
						pos_q <= '0;
						ch_q  <= last_ch ? '0 : ch_q + CW'(1);
					end else begin
						pos_q <= pos_q + PW'(1);
					end
				end
				S_HS_UPD: begin
					hs_q <= keep_tail ? '0 : hp;
				end
				default: begin
					fill_q <= fill_q;
				end
			endcase
		end
	end

endmodule

>>> src/overlapped_frame_buffer.sv
// After a frame's last sample, each result is read in S_EMIT_RD via the shared memory read
// port and loaded into the output register in S_EMIT_LD once it has room. Input takes one
// sample per cycle while a frame fills and none during emit and copy; each kept sample is
// copied to history in S_KEEP_RD and S_KEEP_WR, then S_HS_UPD advances the ring start.
// Reset: asynchronous, active low; history reads as zero until rewritten, every
// register write restarts the frame and clears history at once.
module overlapped_frame_buffer #(
	parameter int MAX_FRAME_LEN = ofb_pkg::MAX_FRAME_LEN,
	parameter int MAX_CHANNELS  = ofb_pkg::MAX_CHANNELS,
	parameter int SAMPLE_BITS   = ofb_pkg::SAMPLE_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ofb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ofb_pkg::CFG_DATA_W-1:0] cfg_data,
	ofb_in_if.sink                         din,
	ofb_out_if.source                      dout
);
	import ofb_pkg::*;

	localparam int DEPTH = MAX_FRAME_LEN * MAX_CHANNELS;
	localparam int AW    = $clog2(DEPTH);

	mem_ctl_t                      mem_ctl;
	oreg_ctl_t                     oreg_ctl;
	logic [AW-1:0]                 frame_waddr;
	logic [AW-1:0]                 frame_raddr;
	logic [AW-1:0]                 hist_addr;
	logic signed [SAMPLE_BITS-1:0] rdata;
	logic                          room;

	ofb_ctrl #(
		.MAX_FRAME_LEN (MAX_FRAME_LEN),
		.MAX_CHANNELS  (MAX_CHANNELS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (din.valid),
		.in_ready    (din.ready),
		.room        (room),
		.mem_ctl     (mem_ctl),
		.frame_waddr (frame_waddr),
		.frame_raddr (frame_raddr),
		.hist_addr   (hist_addr),
		.oreg_ctl    (oreg_ctl)
	);

	ofb_mem #(
		.MAX_FRAME_LEN (MAX_FRAME_LEN),
		.MAX_CHANNELS  (MAX_CHANNELS),
		.SAMPLE_BITS   (SAMPLE_BITS)
	) u_mem (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (mem_ctl),
		.frame_waddr (frame_waddr),
		.frame_raddr (frame_raddr),
		.hist_addr   (hist_addr),
		.wdata       (din.sample),
		.rdata       (rdata)
	);

	ofb_oreg #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_oreg (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (oreg_ctl),
		.data   (rdata),
		.room   (room),
		.dout   (dout)
	);

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import ofb_pkg::*;

	localparam int STORE_DEPTH  = MAX_FRAME_LEN * MAX_CHANNELS;
	localparam int DRAIN_CYCLES = 200;
	localparam int STALL_LIMIT  = 3000;
	localparam int DIRECTED_ITEMS = 19;
	localparam int RANDOM_ITEMS = 220;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] value;
		logic [CHAN_W-1:0]             channel;
		logic [POS_W-1:0]              position;
		logic                          last;
	} overlap_sample_t;

	class overlap_scoreboard;
		logic [WIDTH_W-1:0]     in_width_reg;
		logic [WIDTH_W-1:0]     out_width_reg;
		logic [NCH_W-1:0]       chan_reg;
		logic                   col_major_reg;
		logic [SAMPLE_BITS-1:0] history[STORE_DEPTH];
		logic [SAMPLE_BITS-1:0] frame_buf[STORE_DEPTH];
		int unsigned            ring_head;
		int unsigned            fill;
		overlap_sample_t        expected_q[$];
		int unsigned            errors;

		function new();
			in_width_reg  = WIDTH_W'(1);
			out_width_reg = WIDTH_W'(2);
			chan_reg      = NCH_W'(1);
			col_major_reg = 1'b0;
			errors        = 0;
			restart();
		endfunction

		function void restart();
			foreach (history[i]) begin
				history[i]   = '0;
				frame_buf[i] = '0;
			end
			ring_head = 0;
			fill      = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_INPUT_WIDTH: in_width_reg = data[WIDTH_W-1:0];
				REG_OUTPUT_WIDTH: out_width_reg = data[WIDTH_W-1:0];
				REG_NUM_CHANNELS: chan_reg = data[NCH_W-1:0];
				REG_COL_MAJOR: col_major_reg = data[0];
				default: return;
			endcase
			restart();
		endfunction

		function int unsigned new_len();
			int unsigned w;
			w = in_width_reg;
			if (w == 0) w = 1;
			if (w > MAX_FRAME_LEN) w = MAX_FRAME_LEN;
			return w;
		endfunction

		function int unsigned out_len();
			int unsigned w;
			w = out_width_reg;
			if (w > MAX_FRAME_LEN) w = MAX_FRAME_LEN;
			if (w < new_len()) w = new_len();
			return w;
		endfunction

		function int unsigned chan_count();
			int unsigned c;
			c = chan_reg;
			if (c == 0) c = 1;
			if (c > MAX_CHANNELS) c = MAX_CHANNELS;
			return c;
		endfunction

		function int unsigned frame_len();
			return new_len() * chan_count();
		endfunction

		function int unsigned slot(int unsigned ch, int unsigned pos);
			if (col_major_reg)
				return (pos + new_len() * ch) % STORE_DEPTH;
			return (chan_count() * pos + ch) % STORE_DEPTH;
		endfunction

		function void note_input(logic [SAMPLE_BITS-1:0] s);
			int unsigned iw, ow, nch, ov, n, ch, pos, base;
			overlap_sample_t item;
			iw  = new_len();
			ow  = out_len();
			nch = chan_count();
			ov  = ow - iw;
			if (fill >= iw * nch) fill = 0;
			frame_buf[fill % STORE_DEPTH] = s;
			fill++;
			if (fill < iw * nch) return;
			fill = 0;
			n = 0;
			for (int a = 0; a < (col_major_reg ? nch : ow); a++) begin
				for (int b = 0; b < (col_major_reg ? ow : nch); b++) begin
					ch  = col_major_reg ? a : b;
					pos = col_major_reg ? b : a;
					if (pos < ov)
						item.value = history[(ch * MAX_FRAME_LEN + (ring_head + pos) % ov) % STORE_DEPTH];
					else
						item.value = frame_buf[slot(ch, pos - ov)];
					item.channel  = CHAN_W'(ch);
					item.position = POS_W'(pos);
					item.last     = (n + 1 == ow * nch);
					expected_q.push_back(item);
					n++;
				end
			end
			if (ov == 0) begin
				ring_head = 0;
				return;
			end
			for (ch = 0; ch < nch; ch++) begin
				base = ch * MAX_FRAME_LEN;
				if (ov <= iw) begin
					for (int k = 0; k < ov; k++)
						history[(base + k) % STORE_DEPTH] = frame_buf[slot(ch, iw - ov + k)];
				end else begin
					for (int k = 0; k < iw; k++)
						history[(base + (ring_head + k) % ov) % STORE_DEPTH] = frame_buf[slot(ch, k)];
				end
			end
			ring_head = (ov <= iw) ? 0 : (ring_head + iw) % ov;
		endfunction

		function void check_result(logic signed [SAMPLE_BITS-1:0] value,
				logic [CHAN_W-1:0] channel, logic [POS_W-1:0] position, logic last);
			overlap_sample_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected transfer: out_sample %0d out_channel %0d out_position %0d frame_last %0b",
					$time, value, channel, position, last);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (value !== want.value) begin
				$display("%0t: out_sample expected %0d actual %0d", $time, want.value, value);
				errors++;
			end
			if (channel !== want.channel) begin
				$display("%0t: out_channel expected %0d actual %0d", $time, want.channel, channel);
				errors++;
			end
			if (position !== want.position) begin
				$display("%0t: out_position expected %0d actual %0d", $time, want.position, position);
				errors++;
			end
			if (last !== want.last) begin
				$display("%0t: frame_last expected %0b actual %0b", $time, want.last, last);
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	cfg_reg_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	ofb_in_if  din ();
	ofb_out_if dout ();

	overlap_scoreboard sb;
	int unsigned       items_sent;
	int unsigned       idle_cycles;
	int unsigned       stall_len;
	bit                calm;

	overlapped_frame_buffer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.din       (din),
		.dout      (dout)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 96) return $urandom_range(4, 12);
		return $urandom_range(20, 48);
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] rand_sample();
		case ($urandom_range(0, 11))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			din.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		din.valid  <= 1'b1;
		din.sample <= s;
		@(posedge clk);
		while (!din.ready) @(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic hold_until_drained();
		din.valid <= 1'b0;
		do @(negedge clk); while (sb.expected_q.size() != 0);
	endtask

	task automatic program_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		sb.write_reg(idx, data);
		@(negedge clk);
	endtask

	task automatic configure(input int unsigned iw, input int unsigned ow,
			input int unsigned nch, input int unsigned cm);
		hold_until_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		program_reg(REG_INPUT_WIDTH, CFG_DATA_W'(iw));
		program_reg(REG_OUTPUT_WIDTH, CFG_DATA_W'(ow));
		program_reg(REG_NUM_CHANNELS, CFG_DATA_W'(nch));
		program_reg(REG_COL_MAJOR, CFG_DATA_W'(cm));
		cfg_we <= 1'b0;
	endtask

	task automatic run_frames(input int unsigned frames, input int unsigned extra);
		repeat (frames) begin
			repeat (sb.frame_len()) send_sample(rand_sample());
			if ($urandom_range(0, 7) == 0) hold_until_drained();
		end
		repeat (extra) send_sample(rand_sample());
	endtask

	task automatic random_phase();
		int unsigned iw, ow, nch, total, frames, extra, r;
		r = $urandom_range(0, 99);
		if (r < 8) iw = 0;
		else if (r < 16) iw = $urandom_range(17, 31);
		else if (r < 26) iw = 16;
		else iw = $urandom_range(1, 8);
		r = $urandom_range(0, 99);
		if (r < 15) ow = $urandom_range(0, 31);
		else if (r < 25) ow = $urandom_range(16, 31);
		else ow = iw + $urandom_range(0, 8);
		if (ow > 31) ow = 31;
		nch = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
		calm = ($urandom_range(0, 3) == 0);
		configure(iw, ow, nch, $urandom_range(0, 1));
		total  = sb.frame_len();
		frames = (total >= 32) ? 1 : $urandom_range(2, 64 / total);
		extra  = (total > 1 && $urandom_range(0, 2) == 0) ? $urandom_range(1, total - 1) : 0;
		run_frames(frames, extra);
	endtask

	always @(posedge clk) begin
		if (arst_n && din.valid && din.ready)
			sb.note_input(din.sample);
	end

	always @(posedge clk) begin
		if (arst_n && dout.valid && dout.ready)
			sb.check_result(dout.out_sample, dout.out_channel, dout.out_position, dout.frame_last);
	end

	always @(posedge clk) begin
		if ((din.valid && din.ready) || (dout.valid && dout.ready) || cfg_we) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		dout.ready = 1'b0;
		@(negedge clk);
		forever begin
			stall_len = pick_gap();
			if (stall_len != 0) begin
				dout.ready <= 1'b0;
				repeat (stall_len) @(negedge clk);
			end
			dout.ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(negedge clk);
		end
	end

	initial begin
		sb          = new();
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = REG_INPUT_WIDTH;
		cfg_data    = '0;
		din.valid   = 1'b0;
		din.sample  = '0;
		items_sent  = 0;
		idle_cycles = 0;
		calm        = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_sample(16'h7FFF);
		send_sample(16'h8000);
		send_sample(16'h0000);
		send_sample(16'hFFFF);
		hold_until_drained();
		send_sample(16'h5555);
		send_sample(16'hAAAA);

		configure(0, 31, 7, 1);
		run_frames(2, 0);

		configure(3, 1, 0, 0);
		run_frames(1, 2);

		while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS)
			random_phase();

		hold_until_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
